// File: rtl/catmull_rom_path_follower_defines.svh
// assertion macros for the catmull-rom path follower
// used by the top level only, needs clk and rst_n in scope
`ifndef CATMULL_ROM_PATH_FOLLOWER_DEFINES_SVH
`define CATMULL_ROM_PATH_FOLLOWER_DEFINES_SVH

// same-cycle implication
`define CRPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/crpf_pkg.sv
// shared constants, codes and control structs of the path follower
// no dependencies
`timescale 1ns / 1ps
package crpf_pkg;

  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int NP_W       = PT_AW + 1;
  localparam int COORD_W    = 32;
  localparam int PT_W       = 3 * COORD_W;
  localparam int ELAP_W     = 33;
  localparam int DUR_W      = 32;
  localparam int PROD_W     = ELAP_W + PT_AW;
  localparam int DVD_W      = PROD_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int H_W        = FRAC_BITS + 3;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MUL_W      = DIFF_W + H_W;
  localparam int ACC_W      = MUL_W + 2;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RESTART = 2'd2
  } req_t;

  typedef enum logic {
    CFG_DURATION   = 1'b0,
    CFG_NUM_POINTS = 1'b1
  } cfg_idx_t;

  // point reads of one segment, in issue order
  typedef enum logic [2:0] {
    RD_FIRST = 3'd0,
    RD_LAST  = 3'd1,
    RD_P0    = 3'd2,
    RD_P1    = 3'd3,
    RD_A0    = 3'd4,
    RD_B0    = 3'd5,
    RD_A1    = 3'd6,
    RD_B1    = 3'd7
  } rd_sel_t;

  typedef struct packed {
    logic       elap_add;
    logic       elap_clr;
    logic       div_load;
    logic       div_step;
    logic       t2_ld;
    logic       t3_ld;
    rd_sel_t    rd_sel;
    logic       cap_en;
    rd_sel_t    cap_sel;
    logic       mul_en;
    logic [1:0] term;
    logic [1:0] coord;
    logic       acc_add;
    logic       acc_first;
    logic       res_ld;
    logic       pt_ld;
    logic       meta_ld;
    logic       meta_end;
  } crpf_cmd_t;

  typedef struct packed {
    logic over;
    logic pt_direct;
  } crpf_sts_t;

endpackage

// File: rtl/crpf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module crpf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/crpf_dp.sv
// datapath: config registers, elapsed counter, divider, basis and mac
// depends on crpf_pkg
`timescale 1ns / 1ps
module crpf_dp import crpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  crpf_cmd_t                 cmd,
  output crpf_sts_t                 sts,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [DUR_W-1:0]          cfg_wdata,
  input  logic [15:0]               tick_delta,
  output logic [PT_AW-1:0]          raddr,
  input  logic [PT_W-1:0]           rdata,
  output logic signed [COORD_W-1:0] pos_x,
  output logic signed [COORD_W-1:0] pos_y,
  output logic signed [COORD_W-1:0] pos_z,
  output logic [7:0]                segment,
  output logic                      finished
);

  logic [DUR_W-1:0]  dur_r;
  logic [NP_W-1:0]   npts_r;
  logic [ELAP_W-1:0] elapsed_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DUR_W-1:0]  rem_r;
  logic [FRAC_BITS:0] t2_r, t3_r;
  logic [PT_W-1:0]   pf_r, pl_r, p0_r, p1_r, a0_r, b0_r, a1_r, b1_r;
  logic signed [MUL_W-1:0] mul_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [COORD_W-1:0] pos_r [3];
  logic [7:0]        seg_out_r;
  logic              fin_r;

  logic [DUR_W-1:0]  dur_eff;
  logic [NP_W-1:0]   n;
  logic [PT_AW-1:0]  nm1, nm2, seg, i1, a0, b0, a1, b1;
  logic [FRAC_BITS-1:0] t;
  logic [DUR_W:0]    trial;
  logic              qbit;
  logic              closed;
  logic signed [H_W-1:0] t2s, t3s, ts, h00, h01, h10, h11, opb;
  logic signed [DIFF_W-1:0] opa;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [COORD_W-1:0] sat;
  logic [2*FRAC_BITS:0]   sq;
  logic [2*FRAC_BITS+1:0] cu;

  function automatic logic signed [COORD_W-1:0] crd(input logic [PT_W-1:0] p,
                                                    input logic [1:0] c);
    crd = p[COORD_W*c +: COORD_W];
  endfunction

  // effective config
  always_comb begin
    dur_eff = (dur_r == '0) ? DUR_W'(1) : dur_r;
    if (npts_r == '0) begin
      n = NP_W'(1);
    end else if (32'(npts_r) > MAX_POINTS) begin
      n = NP_W'(MAX_POINTS);
    end else begin
      n = npts_r;
    end
  end

  assign nm1 = PT_AW'(n - NP_W'(1));
  assign nm2 = nm1 - PT_AW'(1);
  assign seg = dvd_r[FRAC_BITS +: PT_AW];
  assign t   = dvd_r[FRAC_BITS-1:0];
  assign i1  = seg + PT_AW'(1);

  assign sts.over      = elapsed_r > {1'b0, dur_eff};
  assign sts.pt_direct = (({1'b0, seg} + NP_W'(1)) >= n) || (t == '0);

  // restoring divider step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign qbit  = trial >= {1'b0, dur_eff};

  // tangent end points
  assign closed = pf_r == pl_r;
  always_comb begin
    a0 = i1;
    b0 = (seg == '0) ? (closed ? nm2 : '0) : seg - PT_AW'(1);
    a1 = (i1 == nm1) ? (closed ? PT_AW'(1) : nm1) : i1 + PT_AW'(1);
    b1 = (i1 == nm1) ? nm2 : seg;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FIRST: raddr = '0;
      RD_LAST:  raddr = nm1;
      RD_P0:    raddr = seg;
      RD_P1:    raddr = i1;
      RD_A0:    raddr = a0;
      RD_B0:    raddr = b0;
      RD_A1:    raddr = a1;
      RD_B1:    raddr = b1;
      default:  raddr = '0;
    endcase
  end

  // hermite basis
  assign sq  = {1'b0, t} * {1'b0, t} + (2*FRAC_BITS+1)'(1 << (FRAC_BITS-1));
  assign cu  = t2_r * t + (2*FRAC_BITS+2)'(1 << (FRAC_BITS-1));
  assign t2s = H_W'(t2_r);
  assign t3s = H_W'(t3_r);
  assign ts  = H_W'(t);
  assign h00 = (t3s <<< 1) - (t2s <<< 1) - t2s + H_W'(1 << FRAC_BITS);
  assign h01 = (t2s <<< 1) + t2s - (t3s <<< 1);
  assign h10 = t3s - (t2s <<< 1) + ts;
  assign h11 = t3s - t2s;

  always_comb begin
    case (cmd.term)
      2'd0: begin
        opa = {crd(p0_r, cmd.coord), 1'b0};
        opb = h00;
      end
      2'd1: begin
        opa = {crd(p1_r, cmd.coord), 1'b0};
        opb = h01;
      end
      2'd2: begin
        opa = DIFF_W'(crd(a0_r, cmd.coord)) - DIFF_W'(crd(b0_r, cmd.coord));
        opb = h10;
      end
      default: begin
        opa = DIFF_W'(crd(a1_r, cmd.coord)) - DIFF_W'(crd(b1_r, cmd.coord));
        opb = h11;
      end
    endcase
  end

  // round half up, then saturate
  assign rnd = (acc_r + ACC_W'(1 << FRAC_BITS)) >>> (FRAC_BITS + 1);
  always_comb begin
    if (rnd > ACC_W'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (rnd < -ACC_W'(33'sh080000000)) begin
      sat = 32'sh80000000;
    end else begin
      sat = COORD_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r     <= DUR_W'(1000);
      npts_r    <= NP_W'(2);
      elapsed_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DURATION:   dur_r  <= cfg_wdata;
          CFG_NUM_POINTS: npts_r <= cfg_wdata[NP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.elap_clr) begin
        elapsed_r <= '0;
      end else if (cmd.elap_add) begin
        elapsed_r <= elapsed_r + ELAP_W'(tick_delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= {PROD_W'(elapsed_r) * PROD_W'(nm1), FRAC_BITS'(0)};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? DUR_W'(trial - {1'b0, dur_eff}) : DUR_W'(trial);
    end
    if (cmd.t2_ld) t2_r <= sq[2*FRAC_BITS -: FRAC_BITS+1];
    if (cmd.t3_ld) t3_r <= cu[FRAC_BITS +: FRAC_BITS+1];
    if (cmd.cap_en) begin
      unique case (cmd.cap_sel)
        RD_FIRST: pf_r <= rdata;
        RD_LAST:  pl_r <= rdata;
        RD_P0:    p0_r <= rdata;
        RD_P1:    p1_r <= rdata;
        RD_A0:    a0_r <= rdata;
        RD_B0:    b0_r <= rdata;
        RD_A1:    a1_r <= rdata;
        RD_B1:    b1_r <= rdata;
        default: ;
      endcase
    end
    if (cmd.mul_en) mul_r <= opa * opb;
    if (cmd.acc_add) acc_r <= (cmd.acc_first ? '0 : acc_r) + ACC_W'(mul_r);
    if (cmd.res_ld) pos_r[cmd.coord] <= sat;
    if (cmd.pt_ld) begin
      pos_r[0] <= crd(rdata, 2'd0);
      pos_r[1] <= crd(rdata, 2'd1);
      pos_r[2] <= crd(rdata, 2'd2);
    end
    if (cmd.meta_ld) begin
      seg_out_r <= cmd.meta_end ? 8'(nm1) : 8'(seg);
      fin_r     <= cmd.meta_end;
    end
  end

  assign pos_x    = pos_r[0];
  assign pos_y    = pos_r[1];
  assign pos_z    = pos_r[2];
  assign segment  = seg_out_r;
  assign finished = fin_r;

endmodule

// File: rtl/crpf_ctrl.sv
// controller: sequences the tick through divide, point reads and mac
// depends on crpf_pkg
`timescale 1ns / 1ps
module crpf_ctrl import crpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [7:0] point_index,
  input  crpf_sts_t  sts,
  output crpf_cmd_t  cmd,
  output logic       ram_we,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_DIV, S_SEL, S_RD, S_MAC, S_OUT_PT, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           coord_r, coord_nxt;
  logic                 running_r, running_nxt;
  logic                 end_r, end_nxt;
  logic                 go;

  assign go        = start && (state_r == S_IDLE);
  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;
  assign ram_we    = go && (req_t'(req_type) == REQ_WRITE) && (32'(point_index) < MAX_POINTS);

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    coord_nxt   = coord_r;
    running_nxt = running_r;
    end_nxt     = end_r;
    cmd.coord   = coord_r;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          case (req_t'(req_type))
            REQ_TICK: begin
              if (running_r) begin
                cmd.elap_add = 1'b1;
                state_nxt    = S_CHK;
              end
            end
            REQ_RESTART: begin
              cmd.elap_clr = 1'b1;
              running_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (sts.over) begin
          cmd.rd_sel  = RD_LAST;
          end_nxt     = 1'b1;
          running_nxt = 1'b0;
          state_nxt   = S_OUT_PT;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cnt_nxt = '0;
        if (sts.pt_direct) begin
          cmd.rd_sel = RD_P0;
          end_nxt    = 1'b0;
          state_nxt  = S_OUT_PT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // read data is registered in the ram, so each read is captured at the step after its issue
        cmd.rd_sel  = rd_sel_t'(cnt_r[2:0]);
        cmd.cap_en  = cnt_r != '0;
        cmd.cap_sel = rd_sel_t'(cnt_r[2:0] - 3'd1);
        cmd.t2_ld   = cnt_r == '0;
        cmd.t3_ld   = cnt_r == DIV_CNT_W'(1);
        cnt_nxt     = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(8)) begin
          cnt_nxt   = '0;
          coord_nxt = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // four products per coordinate, each accumulated in the cycle after its multiply
        cmd.term      = cnt_r[1:0];
        cmd.mul_en    = cnt_r < DIV_CNT_W'(4);
        cmd.acc_add   = (cnt_r >= DIV_CNT_W'(1)) && (cnt_r <= DIV_CNT_W'(4));
        cmd.acc_first = cnt_r == DIV_CNT_W'(1);
        cnt_nxt       = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(5)) begin
          cmd.res_ld  = 1'b1;
          cmd.meta_ld = 1'b1;
          cnt_nxt     = '0;
          if (coord_r == 2'd2) begin
            state_nxt = S_DONE;
          end else begin
            coord_nxt = coord_r + 2'd1;
          end
        end
      end
      S_OUT_PT: begin
        cmd.pt_ld    = 1'b1;
        cmd.meta_ld  = 1'b1;
        cmd.meta_end = end_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      coord_r   <= '0;
      running_r <= 1'b1;
      end_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      coord_r   <= coord_nxt;
      running_r <= running_nxt;
      end_r     <= end_nxt;
    end
  end

endmodule

// File: rtl/catmull_rom_path_follower.sv
// top level of the catmull-rom path follower
// depends on crpf_pkg, crpf_ram, crpf_ctrl, crpf_dp, catmull_rom_path_follower_defines.svh
//
//   channel   handshake          payload
//   input     start / busy       in_req_type, in_point_index, in_coord_*, in_tick_delta
//   result    out_valid strobe   out_pos_*, out_segment, out_finished
//   config    cfg_we             cfg_index, cfg_wdata
//
// a write, a restart or an ignored word is handled in S_IDLE; busy stays low
// a tick that ends the path passes S_CHK and S_OUT_PT and gives its word in S_DONE
// an interior tick runs a 1-bit restoring divide over 57 dividend bits, 8 point
// reads on the single ram read port and four mac products per coordinate
// a tick that lands on a point skips the reads and mac
// reset is synchronous; the point ram is not cleared, the receiver cannot stall
`timescale 1ns / 1ps
`include "catmull_rom_path_follower_defines.svh"
module catmull_rom_path_follower import crpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic [7:0]                in_point_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [15:0]               in_tick_delta,
  // result words
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_pos_x,
  output logic signed [COORD_W-1:0] out_pos_y,
  output logic signed [COORD_W-1:0] out_pos_z,
  output logic [7:0]                out_segment,
  output logic                      out_finished,
  // configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [DUR_W-1:0]          cfg_wdata
);

  crpf_cmd_t        cmd;
  crpf_sts_t        sts;
  logic             ram_we;
  logic [PT_AW-1:0] raddr;
  logic [PT_W-1:0]  rdata;

  // control point store, x in the low word
  crpf_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PT_AW'(in_point_index)),
    .wdata ({in_coord_z, in_coord_y, in_coord_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  crpf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req_type    (in_req_type),
    .point_index (in_point_index),
    .sts         (sts),
    .cmd         (cmd),
    .ram_we      (ram_we),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // arithmetic and result registers
  crpf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tick_delta (in_tick_delta),
    .raddr      (raddr),
    .rdata      (rdata),
    .pos_x      (out_pos_x),
    .pos_y      (out_pos_y),
    .pos_z      (out_pos_z),
    .segment    (out_segment),
    .finished   (out_finished)
  );

  // a result word only shows while a tick is in flight
  `CRPF_ASSERT_NOW(a_valid_busy, out_valid, busy, "result strobe outside a tick")
  // the strobe lasts one cycle
  `CRPF_ASSERT_NEXT(a_valid_pulse, out_valid, !out_valid, "result strobe held")
  // writes and restarts never give a word and never hold the block
  `CRPF_ASSERT_NEXT(a_write_quiet, start && !busy && in_req_type == REQ_WRITE,
                    !out_valid && !busy, "write produced a result")
  `CRPF_ASSERT_NEXT(a_restart_quiet, start && !busy && in_req_type == REQ_RESTART,
                    !out_valid && !busy, "restart produced a result")

endmodule
